### hw/rtl/tick_duration_to_frames_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef TICK_DURATION_TO_FRAMES_UNIT_DEFINES_SVH
`define TICK_DURATION_TO_FRAMES_UNIT_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define TDF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the unit's own clock and reset.
`define TDF_ASSERT(lbl, prop, msg) \
  `TDF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/tdf_pkg.sv
package tdf_pkg;

  localparam int TICKS_PER_QUARTER_DEF = 960;
  localparam int FRACTION_BITS_DEF     = 16;
  localparam int QUEUE_DEPTH           = 2;
  localparam int NUM_W                 = 106;
  localparam int DEN_W                 = 61;

  localparam logic [25:0] USEC_PER_MINUTE = 26'd60000000;
  localparam logic [28:0] TEMPO_MIN       = 29'd20000000;
  localparam logic [28:0] TEMPO_MAX       = 29'd300000000;
  localparam logic [16:0] RATE_A          = 17'd44100;
  localparam logic [16:0] RATE_B          = 17'd48000;
  localparam logic [16:0] RATE_C          = 17'd88200;
  localparam logic [16:0] RATE_D          = 17'd96000;
  localparam logic [16:0] RATE_RESET      = 17'd48000;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_DURATION = 3'd1,
    ST_BAD_TEMPO    = 3'd2,
    ST_BAD_RATE     = 3'd3,
    ST_OVERFLOW     = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [47:0] duration_ticks;
    logic [15:0]        duration_fraction;
    logic [28:0]        tempo_micro_bpm;
  } in_t;

  typedef struct packed {
    logic [62:0] frames;
    status_e     status;
  } out_t;

  typedef struct packed {
    status_e     status;
    logic [62:0] q;
    logic [28:0] tempo;
    logic [16:0] rate;
  } entry_t;

endpackage

### hw/rtl/tdf_front.sv
module tdf_front #(
  parameter int FRACTION_BITS = tdf_pkg::FRACTION_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tdf_pkg::in_t    in_data_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [16:0]     cfg_data_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output tdf_pkg::entry_t push_data_o
);

  localparam logic [15:0] FRAC_MASK = 16'((32'd1 << FRACTION_BITS) - 32'd1);

  logic [16:0] rate_q;
  logic [15:0] frac_m;
  logic        rate_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= tdf_pkg::RATE_RESET;
    end else if (cfg_valid_i) begin
      rate_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  assign frac_m  = in_data_i.duration_fraction & FRAC_MASK;
  assign rate_ok = (rate_q == tdf_pkg::RATE_A) || (rate_q == tdf_pkg::RATE_B) ||
                   (rate_q == tdf_pkg::RATE_C) || (rate_q == tdf_pkg::RATE_D);

  always_comb begin
    push_data_o.q     = (63'(in_data_i.duration_ticks[46:0]) << FRACTION_BITS) |
                        63'(frac_m);
    push_data_o.tempo = in_data_i.tempo_micro_bpm;
    push_data_o.rate  = rate_q;
    if (in_data_i.duration_ticks[47] ||
        ((in_data_i.duration_ticks == 48'sd0) && (frac_m == 16'd0))) begin
      push_data_o.status = tdf_pkg::ST_BAD_DURATION;
    end else if ((in_data_i.tempo_micro_bpm < tdf_pkg::TEMPO_MIN) ||
                 (in_data_i.tempo_micro_bpm > tdf_pkg::TEMPO_MAX)) begin
      push_data_o.status = tdf_pkg::ST_BAD_TEMPO;
    end else if (!rate_ok) begin
      push_data_o.status = tdf_pkg::ST_BAD_RATE;
    end else begin
      push_data_o.status = tdf_pkg::ST_OK;
    end
  end

endmodule

### hw/rtl/tdf_queue.sv
module tdf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tdf_pkg::entry_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output tdf_pkg::entry_t pop_data_o
);

  localparam int DEPTH = tdf_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  tdf_pkg::entry_t mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/tdf_back.sv
module tdf_back #(
  parameter int TICKS_PER_QUARTER = tdf_pkg::TICKS_PER_QUARTER_DEF,
  parameter int FRACTION_BITS     = tdf_pkg::FRACTION_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  tdf_pkg::entry_t pop_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tdf_pkg::out_t   out_data_o
);

  localparam int NW = tdf_pkg::NUM_W;
  localparam int DW = tdf_pkg::DEN_W;

  typedef struct packed {
    tdf_pkg::status_e status;
    logic [48:0]      p_lo;
    logic [47:0]      p_hi;
    logic [44:0]      den_a;
  } s1_t;

  typedef struct packed {
    tdf_pkg::status_e status;
    logic [79:0]      qr;
    logic [44:0]      den_a;
  } s2_t;

  typedef struct packed {
    tdf_pkg::status_e status;
    logic [57:0]      m0;
    logic [57:0]      m1;
    logic [41:0]      m2;
    logic [44:0]      den_a;
  } s3_t;

  typedef struct packed {
    tdf_pkg::status_e status;
    logic [DW-1:0]    den;
    logic [DW-1:0]    rem;
    logic [NW-1:0]    num;
    logic [NW-1:0]    quo;
  } div_t;

  logic  en;
  logic  v1_q, v2_q, v3_q, v4_q;
  s1_t   s1_q, s1_d;
  s2_t   s2_q, s2_d;
  s3_t   s3_q, s3_d;
  div_t  s4_q, s4_d;
  logic  dv_q [NW];
  div_t  dq [NW];
  div_t  dd [NW];
  logic  out_valid_q;
  tdf_pkg::out_t out_q, out_d;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_ready_o = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    s1_d.status = pop_data_i.status;
    s1_d.p_lo   = pop_data_i.q[31:0] * pop_data_i.rate;
    s1_d.p_hi   = pop_data_i.q[62:32] * pop_data_i.rate;
    s1_d.den_a  = pop_data_i.tempo * 16'(TICKS_PER_QUARTER);

    s2_d.status = s1_q.status;
    s2_d.qr     = 80'(s1_q.p_lo) + (80'(s1_q.p_hi) << 32);
    s2_d.den_a  = s1_q.den_a;

    s3_d.status = s2_q.status;
    s3_d.m0     = s2_q.qr[31:0] * tdf_pkg::USEC_PER_MINUTE;
    s3_d.m1     = s2_q.qr[63:32] * tdf_pkg::USEC_PER_MINUTE;
    s3_d.m2     = s2_q.qr[79:64] * tdf_pkg::USEC_PER_MINUTE;
    s3_d.den_a  = s2_q.den_a;

    s4_d.status = s3_q.status;
    s4_d.num    = NW'(s3_q.m0) + (NW'(s3_q.m1) << 32) + (NW'(s3_q.m2) << 64);
    s4_d.den    = DW'(s3_q.den_a) << FRACTION_BITS;
    s4_d.rem    = '0;
    s4_d.quo    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= pop_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    div_t          src;
    logic          src_v;
    logic [DW:0]   rem_n;
    logic [DW+1:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign src   = s4_q;
      assign src_v = v4_q;
    end else begin : g_next
      assign src   = dq[k-1];
      assign src_v = dv_q[k-1];
    end

    always_comb begin
      rem_n          = {src.rem, src.num[NW-1]};
      diff           = {1'b0, rem_n} - {2'b00, src.den};
      ge             = !diff[DW+1];
      dd[k].status   = src.status;
      dd[k].den      = src.den;
      dd[k].rem      = ge ? diff[DW-1:0] : rem_n[DW-1:0];
      dd[k].num      = {src.num[NW-2:0], 1'b0};
      dd[k].quo      = {src.quo[NW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dq[k] <= dd[k];
      end
    end
  end

  always_comb begin
    logic [DW:0] two_r;
    logic        up;
    logic        ovf;
    logic [62:0] sum;
    two_r = {dq[NW-1].rem, 1'b0};
    up    = (two_r > {1'b0, dq[NW-1].den}) ||
            ((two_r == {1'b0, dq[NW-1].den}) && dq[NW-1].quo[0]);
    sum   = dq[NW-1].quo[62:0] + 63'(up);
    ovf   = (|dq[NW-1].quo[NW-1:63]) || ((&dq[NW-1].quo[62:0]) && up);
    if (dq[NW-1].status != tdf_pkg::ST_OK) begin
      out_d.status = dq[NW-1].status;
      out_d.frames = '0;
    end else if (ovf) begin
      out_d.status = tdf_pkg::ST_OVERFLOW;
      out_d.frames = '0;
    end else begin
      out_d.status = tdf_pkg::ST_OK;
      out_d.frames = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

### hw/rtl/tick_duration_to_frames_unit.sv
// Converts a tick duration and a tempo into a frame count at the configured sample rate,
// rounded half to even, with a status code for invalid input and for overflow. One transfer
// is accepted per cycle while the queue is not full, and results leave in order through four
// multiply and sum stages, a 106-stage divider that resolves one quotient bit per stage, and a
// rounding stage. A two-entry queue sits between the input checks and the arithmetic
// pipeline, and the whole pipeline holds while the output transfer is stalled.
module tick_duration_to_frames_unit #(
  parameter int TICKS_PER_QUARTER = tdf_pkg::TICKS_PER_QUARTER_DEF,
  parameter int FRACTION_BITS     = tdf_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tdf_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tdf_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [16:0]   cfg_data_i
);

  logic            push_valid, push_ready, pop_valid, pop_ready;
  tdf_pkg::entry_t push_data, pop_data;

  tdf_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  tdf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  tdf_back #(
    .TICKS_PER_QUARTER(TICKS_PER_QUARTER),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### hw/rtl/tdf_checker.sv
`include "tick_duration_to_frames_unit_defines.svh"

module tdf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input tdf_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input tdf_pkg::out_t out_data_o,
  input logic          cfg_valid_i,
  input logic          cfg_ready_o,
  input logic [16:0]   cfg_data_i
);

  `TDF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "Output transfer dropped while stalled.")
  `TDF_ASSERT(a_err_zero, out_valid_o && (out_data_o.status != tdf_pkg::ST_OK) |-> (out_data_o.frames == 63'd0), "Frames not zero on a failed conversion.")
  `TDF_ASSERT(a_status_code, out_valid_o |-> (out_data_o.status <= tdf_pkg::ST_OVERFLOW), "Status code out of range.")
  `TDF_ASSERT(a_cfg_ready, $past(rst_ni) |-> cfg_ready_o, "Configuration port not ready.")

endmodule

bind tick_duration_to_frames_unit tdf_checker u_tdf_checker (.*);

### bench/tick_duration_to_frames_unit_tb.sv
`timescale 1ns / 100ps

module tick_duration_to_frames_unit_tb;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD      = 500;
  localparam int SETTLE_CYCLES  = 150;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  tdf_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  tdf_pkg::out_t out_data_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [16:0]   cfg_data_i;

  tdf_pkg::in_t  pending_q[$];
  tdf_pkg::out_t expected_frames_q[$];
  logic [16:0]   rate_reg;
  int            mismatch_count;
  int            idle_cycles;
  int            burst_left;
  int            gap_left;
  logic          hold_request;
  int            hold_left;
  logic          calm_mode;
  int            mode_left;
  logic          in_taken;

  tick_duration_to_frames_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic tdf_pkg::out_t frames_for(tdf_pkg::in_t d, logic [16:0] rate);
    tdf_pkg::out_t r;
    logic [127:0]  num;
    logic [127:0]  den;
    logic [127:0]  quo;
    logic [127:0]  rem;
    logic [62:0]   qv;
    r.frames = '0;
    r.status = tdf_pkg::ST_OK;
    if (d.duration_ticks[47] || (d.duration_ticks == 0 && d.duration_fraction == 0)) begin
      r.status = tdf_pkg::ST_BAD_DURATION;
    end else if (d.tempo_micro_bpm < tdf_pkg::TEMPO_MIN ||
                 d.tempo_micro_bpm > tdf_pkg::TEMPO_MAX) begin
      r.status = tdf_pkg::ST_BAD_TEMPO;
    end else if (rate != tdf_pkg::RATE_A && rate != tdf_pkg::RATE_B &&
                 rate != tdf_pkg::RATE_C && rate != tdf_pkg::RATE_D) begin
      r.status = tdf_pkg::ST_BAD_RATE;
    end else begin
      qv  = {d.duration_ticks[46:0], d.duration_fraction};
      num = 128'(qv) * 128'(rate) * 128'(tdf_pkg::USEC_PER_MINUTE);
      den = 128'(d.tempo_micro_bpm) * 128'(tdf_pkg::TICKS_PER_QUARTER_DEF) * 128'(65536);
      quo = num / den;
      rem = num % den;
      if ((rem << 1) > den || ((rem << 1) == den && quo[0])) begin
        quo = quo + 128'd1;
      end
      if (quo > 128'h7FFF_FFFF_FFFF_FFFF) begin
        r.status = tdf_pkg::ST_OVERFLOW;
      end else begin
        r.frames = quo[62:0];
      end
    end
    return r;
  endfunction

  function automatic tdf_pkg::in_t random_request();
    tdf_pkg::in_t d;
    logic [63:0]  w;
    int           kind;
    int           sh;
    kind = $urandom_range(0, 9);
    w    = {$urandom, $urandom};
    sh   = $urandom_range(0, 46);
    d.duration_ticks    = w[47:0] & ((48'd1 << (sh + 1)) - 48'd1);
    d.duration_fraction = 16'($urandom);
    d.tempo_micro_bpm   = 29'($urandom_range(20000000, 300000000));
    if (kind == 0) begin
      d.duration_ticks  = w[47:0];
      d.tempo_micro_bpm = 29'($urandom);
    end else if (kind == 1) begin
      d.duration_ticks = $urandom_range(0, 1) ? -$signed({1'b0, w[46:0]}) : 48'sd0;
      if ($urandom_range(0, 1)) d.duration_fraction = '0;
    end else if (kind == 2) begin
      d.tempo_micro_bpm = $urandom_range(0, 1) ? 29'($urandom_range(0, 19999999))
                                               : 29'($urandom_range(300000001, 536870911));
    end
    return d;
  endfunction

  function automatic tdf_pkg::in_t mk(logic signed [47:0] t, logic [15:0] f,
                                      logic [28:0] b);
    tdf_pkg::in_t d;
    d.duration_ticks    = t;
    d.duration_fraction = f;
    d.tempo_micro_bpm   = b;
    return d;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  task automatic write_rate(input logic [16:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid_i && expected_frames_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Driver: a new transfer is offered only once the previous one has been accepted.
  always @(negedge clk_i) begin
    logic         nv;
    tdf_pkg::in_t nd;
    nv = in_valid_i;
    nd = in_data_i;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        nv = 1'b1;
        nd = pending_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid_i <= nv;
    in_data_i  <= nd;
  end

  // Receiver: alternates between calm and stalling stretches, plus one long hold-off.
  always @(negedge clk_i) begin
    logic nr;
    if (hold_request && hold_left == 0) begin
      hold_left = LONG_HOLD;
    end
    if (mode_left == 0) begin
      calm_mode = $urandom_range(0, 2) == 0;
      mode_left = $urandom_range(10, 200);
    end else begin
      mode_left--;
    end
    if (hold_left > 1) begin
      hold_left--;
      nr = 1'b0;
    end else begin
      nr = calm_mode ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
    out_ready_i <= nr;
  end

  always @(posedge clk_i) begin
    tdf_pkg::out_t got;
    tdf_pkg::out_t want;
    in_taken <= in_valid_i && in_ready_o;
    idle_cycles++;
    if (cfg_valid_i && cfg_ready_o) begin
      rate_reg    = cfg_data_i;
      idle_cycles = 0;
    end
    if (in_valid_i && in_ready_o) begin
      expected_frames_q.push_back(frames_for(in_data_i, rate_reg));
      idle_cycles = 0;
    end
    if (out_valid_o && out_ready_i) begin
      idle_cycles = 0;
      got = out_data_o;
      if (expected_frames_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_frames_q.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.frames !== want.frames)
          report_mismatch($sformatf("frames %0d, expected %0d", got.frames, want.frames));
      end
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [16:0] rates[8];
    int          per_phase;
    rates = '{tdf_pkg::RATE_B, tdf_pkg::RATE_A, tdf_pkg::RATE_C, tdf_pkg::RATE_D,
              17'd0, 17'd131071, 17'd0, tdf_pkg::RATE_B};
    rates[6] = 17'($urandom_range(0, 131071));
    mismatch_count = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    gap_left       = 0;
    hold_request   = 1'b0;
    hold_left      = 0;
    calm_mode      = 1'b1;
    mode_left      = 0;
    rate_reg       = tdf_pkg::RATE_RESET;
    in_taken       = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Ties at 60 BPM and 48 kHz: 12.5 rounds down, 37.5 rounds up; then range and invalid-input cases.
    pending_q.push_back(mk(48'sd0, 16'd16384, 29'd60000000));
    pending_q.push_back(mk(48'sd0, 16'd49152, 29'd60000000));
    pending_q.push_back(mk(48'sh7FFF_FFFF_FFFF, 16'hFFFF, tdf_pkg::TEMPO_MIN));
    pending_q.push_back(mk(48'sh7FFF_FFFF_FFFF, 16'hFFFF, tdf_pkg::TEMPO_MAX));
    pending_q.push_back(mk(48'sh8000_0000_0000, 16'hFFFF, 29'd120000000));
    pending_q.push_back(mk(-48'sd1, 16'd0, 29'd120000000));
    pending_q.push_back(mk(48'sd0, 16'd0, 29'd120000000));
    pending_q.push_back(mk(48'sd0, 16'd1, 29'd120000000));
    pending_q.push_back(mk(48'sd1, 16'd0, 29'd120000000));
    pending_q.push_back(mk(48'sd5, 16'd7, 29'd19999999));
    pending_q.push_back(mk(48'sd5, 16'd7, 29'd300000001));
    pending_q.push_back(mk(48'sd5, 16'd7, 29'd0));
    pending_q.push_back(mk(48'sd5, 16'd7, 29'h1FFF_FFFF));
    pending_q.push_back(mk(-48'sd1, 16'd0, 29'd0));
    drain();

    for (int p = 0; p < 8; p++) begin
      write_rate(rates[p]);
      per_phase = 230;
      if (p == 1) begin
        hold_request = 1'b1;
        for (int k = 0; k < per_phase; k++) pending_q.push_back(random_request());
        wait (hold_left > 0);
        hold_request = 1'b0;
      end else begin
        for (int k = 0; k < per_phase; k++) pending_q.push_back(random_request());
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### tick_duration_to_frames_unit.f
+incdir+hw/rtl
hw/rtl/tdf_pkg.sv
hw/rtl/tdf_front.sv
hw/rtl/tdf_queue.sv
hw/rtl/tdf_back.sv
hw/rtl/tick_duration_to_frames_unit.sv
hw/rtl/tdf_checker.sv
bench/tick_duration_to_frames_unit_tb.sv
